/* rtl/deq_pkg.sv */
// Shared types and codes for the double-ended queue.
package deq_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_PEEK       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] data_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         item_total;
    logic               is_empty;
  } rsp_t;

  // Per-item bookkeeping carried from the pointer logic to the read stage.
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] item_total;
    logic       is_empty;
    logic       fwd_front;
    logic       fwd_back;
  } step_info_t;

endpackage

/* rtl/deq_ram.sv */
// Slot memory: one write port, two registered read ports, read-first.
module deq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [31:0]       wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  output logic [31:0]       rd_data_a,
  output logic [31:0]       rd_data_b
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* rtl/deq_ctrl.sv */
// Front pointer and count: decodes one item into a slot write and two slot reads.
module deq_ctrl #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  deq_pkg::req_t       req,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [31:0]         wr_data,
  output logic [AW-1:0]       rd_front,
  output logic [AW-1:0]       rd_back,
  output deq_pkg::step_info_t info
);

  logic [AW-1:0] front_index;
  logic [CW-1:0] item_count;

  logic [AW-1:0] front_next;
  logic [CW-1:0] count_next;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_index;
  logic [AW:0]   back_sum;
  logic [1:0]    status;
  logic          full;
  logic          empty;

  assign full  = (item_count == CW'(DEPTH));
  assign empty = (item_count == '0);

  always_comb begin
    front_dec = (front_index == '0) ? AW'(DEPTH - 1) : front_index - AW'(1);
    front_inc = (front_index == AW'(DEPTH - 1)) ? '0 : front_index + AW'(1);
    tail_sum  = {1'b0, front_index} + (AW + 1)'(item_count);
    tail_index = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
                                                : AW'(tail_sum);
  end

  always_comb begin
    front_next = front_index;
    count_next = item_count;
    status     = deq_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_addr    = tail_index;
    case (req.op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status = deq_pkg::ST_OVER;
        end else begin
          wr_en      = 1'b1;
          count_next = item_count + CW'(1);
          if (req.op == deq_pkg::OP_PUSH_FRONT) begin
            wr_addr    = front_dec;
            front_next = front_dec;
          end
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = deq_pkg::ST_UNDER;
        end else begin
          count_next = item_count - CW'(1);
          if (req.op == deq_pkg::OP_POP_FRONT) begin
            front_next = front_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Back slot sits at front + count - 1 after the update; junk when empty.
  always_comb begin
    back_sum = {1'b0, front_next} + (AW + 1)'(count_next) - (AW + 1)'(1);
    rd_back  = (back_sum >= (AW + 1)'(DEPTH)) ? AW'(back_sum - (AW + 1)'(DEPTH))
                                              : AW'(back_sum);
  end

  assign rd_front = front_next;
  assign wr_data  = req.data_value;

  assign info.status     = status;
  assign info.item_total = 5'(count_next);
  assign info.is_empty   = (count_next == '0);
  assign info.fwd_front  = wr_en && (rd_front == wr_addr);
  assign info.fwd_back   = wr_en && (rd_back == wr_addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      item_count  <= '0;
    end else if (accept) begin
      front_index <= front_next;
      item_count  <= count_next;
    end
  end

endmodule

/* rtl/double_ended_queue_top.sv */
// Bounded double-ended queue of signed 32-bit values held in a slot memory.
//
// Request channel (req_valid/req_stall/req): one operation per item, push
// front, push back, pop front, pop back or peek; unused op codes peek.
// Response channel (rsp_valid/rsp_stall/rsp): exactly one item per request
// with status, front and back values (0 when empty), count and empty flag.
// A push to a full queue is dropped with overflow; a pop from an empty queue
// reports underflow and leaves the state alone.
// Pipeline: two register stages, slot read then output register; a taken
// request enters the slot read stage, then the output register raises rsp_valid.
// Throughput: one item per cycle while rsp is not stalled. The memory is written
// and both end slots are read at the same edge; a slot written by that item is
// forwarded, so the single write port and two read ports sustain that rate.
// A stalled response holds in the output register; one more item is read
// into the stage behind it, then req_stall rises until rsp is taken.
// Reset clears the pointer, the count and the valid flags of both stages; the slot
// memory is not cleared, as only slots holding values are ever reported.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  deq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output deq_pkg::rsp_t  rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                accept;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [31:0]         wr_data;
  logic [AW-1:0]       rd_front;
  logic [AW-1:0]       rd_back;
  logic [31:0]         rd_data_front;
  logic [31:0]         rd_data_back;
  deq_pkg::step_info_t info;

  logic                s1_valid;
  deq_pkg::step_info_t s1_info;
  logic [31:0]         s1_data;
  logic                s1_move;
  logic [31:0]         front_val;
  logic [31:0]         back_val;

  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = rst || (s1_valid && !s1_move);
  assign accept    = req_valid && !req_stall;

  deq_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req     (req),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_front(rd_front),
    .rd_back (rd_back),
    .info    (info)
  );

  deq_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk      (clk),
    .wr_en    (accept && wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (accept),
    .rd_addr_a(rd_front),
    .rd_addr_b(rd_back),
    .rd_data_a(rd_data_front),
    .rd_data_b(rd_data_back)
  );

  // Hold the pushed value beside the read data for same-slot forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
      s1_data <= wr_data;
    end
  end

  always_comb begin
    front_val = s1_info.fwd_front ? s1_data : rd_data_front;
    back_val  = s1_info.fwd_back ? s1_data : rd_data_back;
    if (s1_info.is_empty) begin
      front_val = '0;
      back_val  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.status      <= s1_info.status;
      rsp.front_value <= front_val;
      rsp.back_value  <= back_val;
      rsp.item_total  <= s1_info.item_total;
      rsp.is_empty    <= s1_info.is_empty;
    end
  end

endmodule

/* rtl/deq_checker.sv */
// Port-level checks on the double-ended queue and their binding.
module deq_checker #(
  parameter int DEPTH = 16
) (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input deq_pkg::rsp_t rsp
);

  localparam bit SmallDepth = (DEPTH < 32);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |-> rsp.front_value == 0 && rsp.back_value == 0)
    else $error("empty queue reports nonzero end values");

  a_under_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == deq_pkg::ST_UNDER |-> rsp.is_empty)
    else $error("underflow on a nonempty queue");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && SmallDepth && rsp.status == deq_pkg::ST_OVER
      |-> rsp.item_total == 5'(DEPTH))
    else $error("overflow below full count");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && SmallDepth |-> rsp.is_empty == (rsp.item_total == 5'd0))
    else $error("empty flag disagrees with count");

endmodule

bind double_ended_queue_top deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);
